// ===== rtl/via_pkg.sv =====
// ----------------------------------------------------------------------------
// via_pkg: shared types and constants for the interface adapter
// Request codes, register numbers, interrupt bits and the state record.
// ----------------------------------------------------------------------------
`default_nettype none
package via_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  localparam logic [3:0] REG_ORB  = 4'h0;
  localparam logic [3:0] REG_ORA  = 4'h1;
  localparam logic [3:0] REG_DDRB = 4'h2;
  localparam logic [3:0] REG_DDRA = 4'h3;
  localparam logic [3:0] REG_T1CL = 4'h4;
  localparam logic [3:0] REG_T1CH = 4'h5;
  localparam logic [3:0] REG_T1LL = 4'h6;
  localparam logic [3:0] REG_T1LH = 4'h7;
  localparam logic [3:0] REG_T2CL = 4'h8;
  localparam logic [3:0] REG_T2CH = 4'h9;
  localparam logic [3:0] REG_SR   = 4'hA;
  localparam logic [3:0] REG_ACR  = 4'hB;
  localparam logic [3:0] REG_PCR  = 4'hC;
  localparam logic [3:0] REG_IFR  = 4'hD;
  localparam logic [3:0] REG_IER  = 4'hE;
  localparam logic [3:0] REG_ORAN = 4'hF;

  localparam logic [6:0] IFR_T1 = 7'h40;
  localparam logic [6:0] IFR_T2 = 7'h20;
  localparam logic [6:0] IFR_SR = 7'h04;

  typedef struct packed {
    logic [7:0]  ora;
    logic [7:0]  orb;
    logic [7:0]  ddra;
    logic [7:0]  ddrb;
    logic [15:0] t1_reload;
    logic [15:0] t1_count;
    logic        t1_run;
    logic        t1_arm;
    logic        t1_pb7;
    logic [7:0]  t2_reload_lo;
    logic [15:0] t2_count;
    logic        t2_run;
    logic        t2_arm;
    logic [7:0]  sr_data;
    logic [3:0]  sr_cnt;
    logic [7:0]  sr_div;
    logic        sr_phase;
    logic [7:0]  acr;
    logic [7:0]  pcr;
    logic [6:0]  ifr;
    logic [6:0]  ier;
    logic        ca2;
    logic        cb2;
    logic        sr_bit;
  } via_state_t;

  // state after reset: PB7 high, shifter idle, CA2 and CB2 high
  localparam via_state_t STATE_RESET = '{
    t1_pb7:   1'b1,
    sr_cnt:   4'd8,
    ca2:      1'b1,
    cb2:      1'b1,
    default:  '0
  };

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pending;
    logic       ramp_active;
    logic       blank_level;
    logic       zero_low;
    logic [7:0] port_a_latch;
    logic [7:0] port_b_latch;
  } via_result_t;

endpackage
`default_nettype wire

// ===== rtl/via_next.sv =====
// ----------------------------------------------------------------------------
// via_next: next-state and result logic
// Applies one tick, read or write to the register state.
// ----------------------------------------------------------------------------
`default_nettype none
module via_next
  import via_pkg::*;
(
  input  via_state_t  cur_i,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  reg_index_i,
  input  logic [7:0]  write_data_i,
  output via_state_t  nxt_o,
  output via_result_t res_o
);

  logic [7:0] rd;
  logic [2:0] mode;
  logic       edge_hit;
  logic       clocked;
  logic       counts;
  logic [15:0] t1_dec;
  logic [15:0] t2_dec;
  via_state_t  s;

  always_comb begin
    s        = cur_i;
    rd       = 8'h00;
    edge_hit = 1'b0;
    mode     = cur_i.acr[4:2];
    clocked  = 1'b0;
    counts   = 1'b0;
    t1_dec   = cur_i.t1_count - 16'd1;
    t2_dec   = cur_i.t2_count - 16'd1;
    case (req_e'(req_type_i))
      REQ_TICK: begin
        if (cur_i.t1_run) begin
          s.t1_count = t1_dec;
          if (t1_dec == 16'hFFFF) begin
            if (cur_i.acr[6]) begin
              s.ifr      = s.ifr | IFR_T1;
              s.t1_pb7   = ~cur_i.t1_pb7;
              s.t1_count = cur_i.t1_reload;
            end else if (cur_i.t1_arm) begin
              s.ifr    = s.ifr | IFR_T1;
              s.t1_pb7 = 1'b1;
              s.t1_arm = 1'b0;
            end
          end
        end
        if (cur_i.t2_run && !cur_i.acr[5]) begin
          s.t2_count = t2_dec;
          if (t2_dec == 16'hFFFF && cur_i.t2_arm) begin
            s.ifr    = s.ifr | IFR_T2;
            s.t2_arm = 1'b0;
          end
        end
        if (cur_i.sr_div != 8'd0) begin
          s.sr_div = cur_i.sr_div - 8'd1;
        end else begin
          s.sr_div   = cur_i.t2_reload_lo;
          edge_hit   = cur_i.sr_phase;
          s.sr_phase = ~cur_i.sr_phase;
        end
        clocked = (mode == 3'd2 || mode == 3'd6) ||
                  ((mode == 3'd1 || mode == 3'd5 || mode == 3'd4) && edge_hit);
        counts  = (mode == 3'd1 || mode == 3'd2 || mode == 3'd5 || mode == 3'd6);
        if (!cur_i.sr_cnt[3] && clocked) begin
          if (!mode[2]) begin
            s.sr_data = {cur_i.sr_data[6:0], 1'b0};
          end else begin
            s.sr_bit  = cur_i.sr_data[7];
            s.sr_data = {cur_i.sr_data[6:0], cur_i.sr_data[7]};
          end
          if (counts) begin
            s.sr_cnt = cur_i.sr_cnt + 4'd1;
            if (cur_i.sr_cnt == 4'd7) s.ifr = s.ifr | IFR_SR;
          end
        end
        if ((cur_i.pcr & 8'h0E) == 8'h0A) s.ca2 = 1'b1;
        if ((cur_i.pcr & 8'hE0) == 8'hA0) s.cb2 = 1'b1;
      end
      REQ_READ: begin
        case (reg_index_i)
          REG_ORB: begin
            if (cur_i.acr[7]) rd = (cur_i.orb & 8'h5F) | {cur_i.t1_pb7, 7'd0};
            else              rd = cur_i.orb & 8'hDF;
          end
          REG_DDRB: rd = cur_i.ddrb;
          REG_DDRA: rd = cur_i.ddra;
          REG_T1CL: begin
            s.ifr    = cur_i.ifr & ~IFR_T1;
            s.t1_run = 1'b0;
            s.t1_arm = 1'b0;
            s.t1_pb7 = 1'b1;
            rd       = cur_i.t1_count[7:0];
          end
          REG_T1CH: rd = cur_i.t1_count[15:8];
          REG_T1LL: rd = cur_i.t1_reload[7:0];
          REG_T1LH: rd = cur_i.t1_reload[15:8];
          REG_T2CL: begin
            s.ifr    = cur_i.ifr & ~IFR_T2;
            s.t2_run = 1'b0;
            s.t2_arm = 1'b0;
            rd       = cur_i.t2_count[7:0];
          end
          REG_T2CH: rd = cur_i.t2_count[15:8];
          REG_SR: begin
            s.ifr      = cur_i.ifr & ~IFR_SR;
            s.sr_cnt   = 4'd0;
            s.sr_phase = 1'b1;
            rd         = cur_i.sr_data;
          end
          REG_ACR: rd = cur_i.acr;
          REG_PCR: rd = cur_i.pcr;
          REG_IFR: rd = {|(cur_i.ifr & cur_i.ier), cur_i.ifr};
          REG_IER: rd = {1'b1, cur_i.ier};
          default: rd = (cur_i.ora & cur_i.ddra) | ~cur_i.ddra;
        endcase
      end
      REQ_WRITE: begin
        case (reg_index_i)
          REG_ORB:  s.orb  = write_data_i;
          REG_ORA,
          REG_ORAN: s.ora  = write_data_i;
          REG_DDRB: s.ddrb = write_data_i;
          REG_DDRA: s.ddra = write_data_i;
          REG_T1CL,
          REG_T1LL: s.t1_reload[7:0] = write_data_i;
          REG_T1CH: begin
            s.t1_reload = {write_data_i, cur_i.t1_reload[7:0]};
            s.t1_count  = {write_data_i, cur_i.t1_reload[7:0]};
            s.ifr       = cur_i.ifr & ~IFR_T1;
            s.t1_run    = 1'b1;
            s.t1_arm    = 1'b1;
            s.t1_pb7    = 1'b0;
          end
          REG_T1LH: s.t1_reload[15:8] = write_data_i;
          REG_T2CL: s.t2_reload_lo = write_data_i;
          REG_T2CH: begin
            s.t2_count = {write_data_i, cur_i.t2_reload_lo};
            s.ifr      = cur_i.ifr & ~IFR_T2;
            s.t2_run   = 1'b1;
            s.t2_arm   = 1'b1;
          end
          REG_SR: begin
            s.sr_data  = write_data_i;
            s.ifr      = cur_i.ifr & ~IFR_SR;
            s.sr_cnt   = 4'd0;
            s.sr_phase = 1'b1;
          end
          REG_ACR: s.acr = write_data_i;
          REG_PCR: begin
            s.pcr = write_data_i;
            s.ca2 = (write_data_i & 8'h0E) != 8'h0C;
            s.cb2 = (write_data_i & 8'hE0) != 8'hC0;
          end
          REG_IFR: s.ifr = cur_i.ifr & ~write_data_i[6:0];
          default: begin
            if (write_data_i[7]) s.ier = cur_i.ier | write_data_i[6:0];
            else                 s.ier = cur_i.ier & ~write_data_i[6:0];
          end
        endcase
      end
      default: ;
    endcase
  end

  assign nxt_o = s;

  always_comb begin
    res_o.read_data    = rd;
    res_o.irq_pending  = |(s.ifr & s.ier);
    res_o.ramp_active  = s.acr[7] ? ~s.t1_pb7 : ~s.orb[7];
    res_o.blank_level  = s.acr[4] ? s.sr_bit : s.cb2;
    res_o.zero_low     = ~s.ca2;
    res_o.port_a_latch = s.ora;
    res_o.port_b_latch = s.orb;
  end

endmodule
`default_nettype wire

// ===== rtl/versatile_interface_adapter_core.sv =====
// ----------------------------------------------------------------------------
// versatile_interface_adapter_core: 6522-style interface adapter
// Port latches, two timers, shift register, control and interrupt registers.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// in       to block   req_type, reg_index, write_data
// out      from block read_data, irq_pending, ramp_active, blank_level,
//                     zero_low, port_a_latch, port_b_latch
//
// One item per cycle while the output does not stall: the state update and
// result are one combinational pass from the register state into the result
// register. A new transfer is taken whenever the result register is empty or
// is being taken in the same cycle; a stall on the output holds the input.
// Reset loads the documented state; no clearing pass is needed.
`default_nettype none
module versatile_interface_adapter_core
  import via_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [3:0] reg_index_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       irq_pending_o,
  output logic       ramp_active_o,
  output logic       blank_level_o,
  output logic       zero_low_o,
  output logic [7:0] port_a_latch_o,
  output logic [7:0] port_b_latch_o
);

  via_state_t  state_q, state_d;
  via_result_t res_q, res_d;
  logic        vld_q;
  logic        take;

  // accept when the result slot is free or draining this cycle
  assign in_ready_o = ~vld_q | out_ready_i;
  assign take       = in_valid_i & in_ready_o;

  via_next u_next (
    .cur_i       (state_q),
    .req_type_i  (req_type_i),
    .reg_index_i (reg_index_i),
    .write_data_i(write_data_i),
    .nxt_o       (state_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
      vld_q   <= 1'b0;
    end else begin
      if (take) begin
        state_q <= state_d;
      end
      // advance the result flag on a new transfer, drop it once taken
      if (take) begin
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = vld_q;
  assign read_data_o    = res_q.read_data;
  assign irq_pending_o  = res_q.irq_pending;
  assign ramp_active_o  = res_q.ramp_active;
  assign blank_level_o  = res_q.blank_level;
  assign zero_low_o     = res_q.zero_low;
  assign port_a_latch_o = res_q.port_a_latch;
  assign port_b_latch_o = res_q.port_b_latch;

endmodule
`default_nettype wire

// ===== rtl/via_checker.sv =====
// ----------------------------------------------------------------------------
// via_checker: port-level checks for the adapter
// Watches the handshakes and result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none
module via_checker
  import via_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_o,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire [1:0] req_type_i,
  input wire [7:0] read_data_o,
  input wire [7:0] port_a_latch_o
);

  // a transfer always produces a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o) else $error("result missing");

  // ready whenever output is empty
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("ready low while empty");

  // ticks and writes return zero read data
  a_rdzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_TICK || req_type_i == REQ_WRITE)
    |=> read_data_o == 8'h00) else $error("read data not zero");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(port_a_latch_o))
    else $error("stalled result changed");

endmodule

bind versatile_interface_adapter_core via_checker u_via_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .req_type_i(req_type_i),
  .read_data_o(read_data_o), .port_a_latch_o(port_a_latch_o)
);
`default_nettype wire
